### rtl/akr_pkg.sv
`default_nettype none

package akr_pkg;

   localparam int LINE_COUNT_DEF = 9;
   localparam int TIME_W         = 32;
   localparam int MS_W           = 16;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [MS_W-1:0] RESET_INITIAL_DELAY = 16'd380;
   localparam logic [MS_W-1:0] RESET_FAST_INTERVAL = 16'd55;
   localparam logic [MS_W-1:0] RESET_INTERVAL_STEP = 16'd35;
   localparam logic [31:0]     RESET_REPEAT_MASK   = 32'd63;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INITIAL_DELAY = 2'd0,
      REG_FAST_INTERVAL = 2'd1,
      REG_INTERVAL_STEP = 2'd2,
      REG_REPEAT_MASK   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [MS_W-1:0] initial_delay;
      logic [MS_W-1:0] fast_interval;
      logic [MS_W-1:0] interval_step;
   } timing_type;

endpackage

`default_nettype wire

### rtl/akr_lane.sv
`default_nettype none

module akr_lane
   import akr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire timing_type        timing,
   input  wire logic              repeat_en,
   input  wire logic              take,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic              down,
   output logic                   fired
);

   logic              was_held_ff;
   logic              was_held_in;
   logic [MS_W-1:0]   interval_ff;
   logic [MS_W-1:0]   interval_in;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] deadline_in;
   logic              press;
   logic              repeat_hit;
   logic [MS_W:0]     limit;
   logic [MS_W-1:0]   shrunk;

   always_comb begin
      press       = down && !was_held_ff;
      repeat_hit  = down && was_held_ff && repeat_en && (now_ms >= deadline_ff);
      fired       = press || repeat_hit;
      limit       = {1'b0, timing.fast_interval} + {1'b0, timing.interval_step};
      shrunk      = ({1'b0, interval_ff} > limit) ? interval_ff - timing.interval_step
                                                  : timing.fast_interval;
      interval_in = press ? timing.initial_delay : shrunk;
      deadline_in = now_ms + TIME_W'(interval_in);
      was_held_in = down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_held_ff <= 1'b0;
      end else if (take) begin
         was_held_ff <= was_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && fired) begin
         interval_ff <= interval_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

`default_nettype wire

### rtl/akr_merge.sv
`default_nettype none

module akr_merge
   import akr_pkg::*;
#(
   parameter int LINE_COUNT = LINE_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [LINE_COUNT-1:0] lane_fired,
   output logic                       push_ready,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [LINE_COUNT-1:0]      out_fired
);

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [LINE_COUNT-1:0] out_data_ff;
   logic [LINE_COUNT-1:0] out_data_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [LINE_COUNT-1:0] skid_data_ff;
   logic [LINE_COUNT-1:0] skid_data_in;
   logic                  pop;

   always_comb begin
      pop           = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = lane_fired;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = lane_fired;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_fired  = out_data_ff;

endmodule

`default_nettype wire

### rtl/accelerating_key_repeat.sv
// a poll's result is registered in the output stage, or in the skid entry
// throughput: one poll per cycle unless stalled, all lines updated at once
// a two-entry output stage lets a poll transfer while a result waits
// reset: synchronous, active high; clears held history and output valids,
// loads the timing registers with their default values
`default_nettype none

module accelerating_key_repeat
   import akr_pkg::*;
#(
   parameter int LINE_COUNT = LINE_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // now_ms, held_lines
   input  wire logic [((TIME_W+LINE_COUNT+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // fired_lines
   output logic [((LINE_COUNT+7)/8)*8-1:0]        rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [((LINE_COUNT > MS_W) ? LINE_COUNT : MS_W)-1:0] csr_data
);

   localparam int RSP_W = ((LINE_COUNT + 7) / 8) * 8;

   timing_type            timing_ff;
   timing_type            timing_in;
   logic [LINE_COUNT-1:0] repeat_mask_ff;
   logic [LINE_COUNT-1:0] repeat_mask_in;
   logic                  take;
   logic [TIME_W-1:0]     now_ms;
   logic [LINE_COUNT-1:0] held_lines;
   logic [LINE_COUNT-1:0] lane_fired;
   logic [LINE_COUNT-1:0] fired_lines;

   assign csr_ready  = 1'b1;
   assign take       = req_tvalid && req_tready;
   assign now_ms     = req_tdata[TIME_W-1:0];
   assign held_lines = req_tdata[TIME_W+LINE_COUNT-1:TIME_W];

   always_comb begin
      timing_in      = timing_ff;
      repeat_mask_in = repeat_mask_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_INITIAL_DELAY: timing_in.initial_delay = csr_data[MS_W-1:0];
            REG_FAST_INTERVAL: timing_in.fast_interval = csr_data[MS_W-1:0];
            REG_INTERVAL_STEP: timing_in.interval_step = csr_data[MS_W-1:0];
            REG_REPEAT_MASK:   repeat_mask_in          = csr_data[LINE_COUNT-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.initial_delay <= RESET_INITIAL_DELAY;
         timing_ff.fast_interval <= RESET_FAST_INTERVAL;
         timing_ff.interval_step <= RESET_INTERVAL_STEP;
         repeat_mask_ff          <= RESET_REPEAT_MASK[LINE_COUNT-1:0];
      end else begin
         timing_ff      <= timing_in;
         repeat_mask_ff <= repeat_mask_in;
      end
   end

   for (genvar i = 0; i < LINE_COUNT; i++) begin : g_lane
      akr_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .timing    (timing_ff),
         .repeat_en (repeat_mask_ff[i]),
         .take      (take),
         .now_ms    (now_ms),
         .down      (held_lines[i]),
         .fired     (lane_fired[i])
      );
   end

   akr_merge #(
      .LINE_COUNT (LINE_COUNT)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .lane_fired (lane_fired),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_fired  (fired_lines)
   );

   assign rsp_tdata = RSP_W'(fired_lines);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("no result after a poll transfer");

   a_fire_needs_held: assert property (@(posedge clock) disable iff (reset)
      take |-> ((lane_fired & ~held_lines) == '0))
      else $error("a released line fired");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import akr_pkg::*;

   localparam int REQ_W = ((TIME_W + LINE_COUNT_DEF + 7) / 8) * 8;
   localparam int RSP_W = ((LINE_COUNT_DEF + 7) / 8) * 8;
   localparam int CSR_W = (LINE_COUNT_DEF > MS_W) ? LINE_COUNT_DEF : MS_W;

   typedef struct packed {
      logic [TIME_W-1:0]         now_ms;
      logic [LINE_COUNT_DEF-1:0] held_lines;
   } poll_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   accelerating_key_repeat DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // predictor copy of the timing registers and per-line state
   logic [MS_W-1:0] cfg_initial = RESET_INITIAL_DELAY;
   logic [MS_W-1:0] cfg_fast    = RESET_FAST_INTERVAL;
   logic [MS_W-1:0] cfg_step    = RESET_INTERVAL_STEP;
   logic [LINE_COUNT_DEF-1:0] cfg_repeat = RESET_REPEAT_MASK[LINE_COUNT_DEF-1:0];
   logic [LINE_COUNT_DEF-1:0] line_held = '0;
   logic [MS_W-1:0]   line_interval [LINE_COUNT_DEF] = '{default: '0};
   logic [TIME_W-1:0] line_deadline [LINE_COUNT_DEF] = '{default: '0};

   poll_type poll_q[$];
   logic [LINE_COUNT_DEF-1:0] fired_q[$];
   poll_type cur_poll;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_rsp = 1'b0;
   logic pressure_go = 1'b0;
   logic [TIME_W-1:0] now_cursor = '0;
   logic [LINE_COUNT_DEF-1:0] held_cursor = '0;

   function automatic logic [LINE_COUNT_DEF-1:0] predict_fired(poll_type p);
      logic [LINE_COUNT_DEF-1:0] fired;
      logic [MS_W:0] floor_sum;
      logic [MS_W-1:0] iv;
      int i;
      fired = '0;
      floor_sum = {1'b0, cfg_fast} + {1'b0, cfg_step};
      for (i = 0; i < LINE_COUNT_DEF; i++) begin
         if (p.held_lines[i] && !line_held[i]) begin
            fired[i] = 1'b1;
            line_interval[i] = cfg_initial;
            line_deadline[i] = p.now_ms + {16'b0, cfg_initial};
         end else if (p.held_lines[i] && cfg_repeat[i] && p.now_ms >= line_deadline[i]) begin
            iv = ({1'b0, line_interval[i]} > floor_sum) ? line_interval[i] - cfg_step
                                                          : cfg_fast;
            fired[i] = 1'b1;
            line_interval[i] = iv;
            line_deadline[i] = p.now_ms + {16'b0, iv};
         end
         line_held[i] = p.held_lines[i];
      end
      return fired;
   endfunction

   // poll driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            fired_q.push_back(predict_fired(cur_poll));
         end
         if (!req_tvalid || req_tready) begin
            if (poll_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_poll = poll_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_W'({cur_poll.held_lines, cur_poll.now_ms});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      logic [LINE_COUNT_DEF-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fired_q.size() == 0) begin
               $error("fired_lines expected none actual %h", rsp_tdata[LINE_COUNT_DEF-1:0]);
               errors++;
            end else begin
               want = fired_q.pop_front();
               if (rsp_tdata[LINE_COUNT_DEF-1:0] !== want) begin
                  $error("fired_lines expected %h actual %h", want,
                         rsp_tdata[LINE_COUNT_DEF-1:0]);
                  errors++;
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off while polls keep coming
   initial begin
      wait (pressure_go);
      hold_rsp <= 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   task automatic add_poll(logic [TIME_W-1:0] now, logic [LINE_COUNT_DEF-1:0] held);
      poll_type p;
      p.now_ms = now;
      p.held_lines = held;
      poll_q.push_back(p);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_INITIAL_DELAY: cfg_initial = value[MS_W-1:0];
         REG_FAST_INTERVAL: cfg_fast = value[MS_W-1:0];
         REG_INTERVAL_STEP: cfg_step = value[MS_W-1:0];
         REG_REPEAT_MASK:   cfg_repeat = value[LINE_COUNT_DEF-1:0];
         default: ;
      endcase
   endtask

   // sampled mid-cycle so that transfers of the last edge have settled
   task automatic drain();
      while (poll_q.size() > 0 || req_tvalid || fired_q.size() > 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random(int n, int max_step);
      logic [TIME_W-1:0] now;
      logic [LINE_COUNT_DEF-1:0] held;
      int k;
      int b;
      int pick;
      now = now_cursor;
      held = held_cursor;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            now = $urandom;
         end else if (pick < 7) begin
            now = 32'hFFFF_FFFF - $urandom_range(0, max_step * 4);
         end else begin
            now = now + $urandom_range(0, max_step);
         end
         if ($urandom_range(0, 99) < 6) begin
            held = LINE_COUNT_DEF'($urandom);
         end else begin
            for (b = 0; b < LINE_COUNT_DEF; b++) begin
               if ($urandom_range(0, 9) == 0) held[b] = ~held[b];
            end
         end
         add_poll(now, held);
      end
      now_cursor = now;
      held_cursor = held;
   endtask

   task automatic run_phase(logic [CSR_W-1:0] init, logic [CSR_W-1:0] fast,
                            logic [CSR_W-1:0] step, logic [CSR_W-1:0] mask,
                            int n, int max_step, int send_pct, int recv_pct);
      write_reg(REG_INITIAL_DELAY, init);
      write_reg(REG_FAST_INTERVAL, fast);
      write_reg(REG_INTERVAL_STEP, step);
      write_reg(REG_REPEAT_MASK, mask);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queue_random(n, max_step);
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed polls under the reset timing
      send_idle_pct = 34;
      recv_idle_pct = 81;
      add_poll(32'd0, 9'h000);
      add_poll(32'd10, 9'h1FF);
      add_poll(32'd100, 9'h1FF);
      add_poll(32'd390, 9'h1FF);
      add_poll(32'd735, 9'h1FF);
      add_poll(32'd1045, 9'h1FF);
      add_poll(32'd1100, 9'h0AA);
      add_poll(32'd1101, 9'h1FF);
      add_poll(32'd5000, 9'h1FF);
      add_poll(32'd5000, 9'h1FF);
      add_poll(32'd5000, 9'h000);
      add_poll(32'hFFFF_FF00, 9'h001);
      add_poll(32'hFFFF_FF01, 9'h001);
      add_poll(32'hFFFF_FFFF, 9'h1FF);
      add_poll(32'd0, 9'h1FF);
      add_poll(32'd200, 9'h155);
      add_poll(32'd1000, 9'h155);
      add_poll(32'd0, 9'h000);
      add_poll(32'hFFFF_FFFF, 9'h100);
      add_poll(32'hFFFF_FFFF, 9'h100);
      drain();

      send_idle_pct = 34;
      recv_idle_pct = 81;
      queue_random(30, 80);
      drain();
      run_phase(16'd10, 16'd2, 16'd3, 16'h01FF, 70, 6, 34, 81);
      run_phase(16'd0, 16'd0, 16'd0, 16'hFFFF, 70, 3, 34, 81);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFE00 | 16'($urandom_range(0, 511)),
                60, 20000, 81, 34);
      run_phase(16'd200, 16'd20, 16'hFFFF, 16'($urandom), 70, 60, 81, 34);
      run_phase(16'd1000, 16'd0, 16'd100, 16'h01FF, 70, 150, 81, 34);

      // receiver stalls for a long stretch while polls keep arriving
      write_reg(REG_INITIAL_DELAY, 16'd30);
      write_reg(REG_FAST_INTERVAL, 16'd4);
      write_reg(REG_INTERVAL_STEP, 16'd5);
      write_reg(REG_REPEAT_MASK, 16'h01FF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(70, 12);
      pressure_go = 1'b1;
      drain();

      run_phase(16'($urandom_range(0, 400)), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 60)), 16'($urandom), 50, 50, 0, 0);
      run_phase(16'd50, 16'hFFFF, 16'd0, 16'h0155, 40, 40, 0, 0);

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
